@@ design/assert_macros.svh @@
// Assertion macros for the RTL of the 2x2 box-average downscaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define BOXDS_ASSERT_AT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("boxds: invariant violated");
// Consequence must hold in the cycle after the antecedent.
`define BOXDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boxds: sequence violated");
`else
`define BOXDS_ASSERT_AT(lbl, clk, rst_n, expr)
`define BOXDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/boxds_pkg.sv @@
// Shared types and constants of the 2x2 box-average downscaler.
`timescale 1ns / 1ps
`default_nettype none

package boxds_pkg;

    localparam int CH_W   = 8;
    localparam int SUM_W  = 9;
    localparam int LINE_W = 3 * SUM_W;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 16;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

    // register select (byte address bit 2)
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    // position of the pixel being accepted
    typedef struct packed {
        logic pair_end;    // second pixel of a horizontal pair
        logic row_odd;     // pixel lies on an odd row
        logic frame_last;  // last output pixel of the frame
    } t_pos_info;

    // pipeline occupancy of the averaging datapath
    typedef struct packed {
        logic s1_valid;
        logic out_valid;
    } t_avg_status;

endpackage

`default_nettype wire

@@ design/box_average_downscale_2x2_core.sv @@
// Top level of the 2x2 box-average RGB downscaler.
//
// Pixels enter in raster order on the input channel (i_in_valid/o_in_ready,
// one 24-bit RGB pixel per transaction). Each 2x2 block yields one output
// transaction (o_out_valid/i_out_ready) carrying the truncated per-channel
// mean; o_frame_done marks the last output of the frame, after which the
// raster counters wrap. A trailing odd column or row is consumed silently.
// Throughput: one pixel per clock unless the receiver stalls. After the
// transaction of the pixel that completes its block, the output passes the
// line store read, then the output register.
// Image size is set over the APB port (width at 0x0, height at 0x4) and may
// only change while the block is idle. Reset loads 640x480 and clears the
// counters; the line store needs no clearing, since each entry is written
// on an even row before an odd row reads it.
// When the receiver stalls, the result holds in the output register and one
// more block can wait in stage 1; only then does o_in_ready drop.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module box_average_downscale_2x2_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input pixel channel
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [boxds_pkg::CH_W-1:0]          i_red_in,
    input  wire  [boxds_pkg::CH_W-1:0]          i_green_in,
    input  wire  [boxds_pkg::CH_W-1:0]          i_blue_in,
    // output pixel channel
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [boxds_pkg::CH_W-1:0]          o_red_out,
    output logic [boxds_pkg::CH_W-1:0]          o_green_out,
    output logic [boxds_pkg::CH_W-1:0]          o_blue_out,
    output logic                                o_frame_done,
    // configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [2:0]                          paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [boxds_pkg::WIDTH_REG_W-1:0]  r_image_width;
    logic [boxds_pkg::HEIGHT_REG_W-1:0] r_image_height;

    boxds_pkg::t_pos_info   pos_info;
    boxds_pkg::t_avg_status avg_status;
    boxds_pkg::t_pixel      in_pixel;

    logic [ADDR_W-1:0]            slot;
    logic [boxds_pkg::LINE_W-1:0] line_wdata;
    logic [boxds_pkg::LINE_W-1:0] line_rdata;
    logic                         in_accept;
    logic                         cfg_write;
    logic                         line_we;
    logic                         line_re;

    assign in_accept = i_in_valid && o_in_ready;
    assign in_pixel  = '{blue: i_blue_in, green: i_green_in, red: i_red_in};

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= boxds_pkg::WIDTH_RESET;
            r_image_height <= boxds_pkg::HEIGHT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                boxds_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= pwdata[boxds_pkg::WIDTH_REG_W-1:0];
                end
                boxds_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= pwdata[boxds_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            boxds_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            boxds_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:                     prdata = '0;
        endcase
    end

    // raster position
    boxds_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_info         (pos_info),
        .o_slot         (slot)
    );

    // even rows store pair sums, odd rows read them back
    assign line_we = in_accept && pos_info.pair_end && !pos_info.row_odd;
    assign line_re = in_accept && pos_info.pair_end && pos_info.row_odd;

    boxds_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (slot),
        .i_wdata (line_wdata),
        .i_re    (line_re),
        .i_raddr (slot),
        .o_rdata (line_rdata)
    );

    // averaging datapath and output register
    boxds_avg u_avg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_info       (pos_info),
        .i_pixel      (in_pixel),
        .i_line_rdata (line_rdata),
        .i_out_ready  (i_out_ready),
        .o_line_wdata (line_wdata),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_red        (o_red_out),
        .o_green      (o_green_out),
        .o_blue       (o_blue_out),
        .o_done       (o_frame_done),
        .o_status     (avg_status)
    );

    // a block-completing pixel always reaches stage 1
    `BOXDS_ASSERT_NEXT(a_emit_tracked, i_clk, i_rst_n, in_accept && pos_info.pair_end && pos_info.row_odd, avg_status.s1_valid)
    // a stalled stage 1 keeps its block
    `BOXDS_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, avg_status.s1_valid && avg_status.out_valid && !i_out_ready, avg_status.s1_valid)
    // frame end is only flagged on a block-completing pixel
    `BOXDS_ASSERT_AT(a_last_on_emit, i_clk, i_rst_n, !(in_accept && pos_info.frame_last) || (pos_info.pair_end && pos_info.row_odd))

endmodule

`default_nettype wire

@@ design/boxds_pos.sv @@
// Column and row counters of the input raster, with frame-end detection.
`timescale 1ns / 1ps
`default_nettype none

module boxds_pos #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_accept,
    input  wire  [boxds_pkg::WIDTH_REG_W-1:0]       i_image_width,
    input  wire  [boxds_pkg::HEIGHT_REG_W-1:0]      i_image_height,
    output boxds_pkg::t_pos_info                    o_info,
    output logic [ADDR_W-1:0]                       o_slot
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CMP_W      = (COL_W + 1 > boxds_pkg::WIDTH_REG_W) ?
                                COL_W + 1 : boxds_pkg::WIDTH_REG_W;
    localparam int ROW_W      = boxds_pkg::HEIGHT_REG_W;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [CMP_W-1:0] w_cfg;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] last_col;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] col_half;
    logic             row_end;
    logic             frame_end;
    logic             size_ok;

    // effective width saturates at the line store capacity
    assign w_cfg = CMP_W'(i_image_width);
    assign w_eff = (w_cfg > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_cfg;

    assign col_ext   = CMP_W'(r_col);
    assign col_inc   = col_ext + CMP_W'(1);
    assign row_end   = (col_inc >= w_eff);
    assign row_inc   = {1'b0, r_row} + (ROW_W + 1)'(1);
    assign frame_end = (row_inc >= {1'b0, i_image_height});

    // last full 2x2 block; odd trailing column/row is dropped
    assign last_col = {w_eff[CMP_W-1:1], 1'b0} - CMP_W'(1);
    assign last_row = {i_image_height[ROW_W-1:1], 1'b0} - ROW_W'(1);
    assign size_ok  = (w_eff >= CMP_W'(2)) && (i_image_height >= ROW_W'(2));

    assign o_info.pair_end   = r_col[0];
    assign o_info.row_odd    = r_row[0];
    assign o_info.frame_last = size_ok && (col_ext == last_col) && (r_row == last_row);

    assign col_half = r_col >> 1;
    assign o_slot   = col_half[ADDR_W-1:0];

    // raster counters, advanced per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : row_inc[ROW_W-1:0];
            end else begin
                r_col <= col_inc[COL_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/boxds_line_mem.sv @@
// Line store of horizontal pair sums: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module boxds_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire  [ADDR_W-1:0]                i_waddr,
    input  wire  [boxds_pkg::LINE_W-1:0]     i_wdata,
    input  wire                              i_re,
    input  wire  [ADDR_W-1:0]                i_raddr,
    output logic [boxds_pkg::LINE_W-1:0]     o_rdata
);

    logic [boxds_pkg::LINE_W-1:0] r_mem [0:DEPTH-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/boxds_avg.sv @@
// Pair-sum and 2x2 averaging datapath with output register and flow control.
`timescale 1ns / 1ps
`default_nettype none

module boxds_avg (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_accept,
    input  boxds_pkg::t_pos_info                i_info,
    input  boxds_pkg::t_pixel                   i_pixel,
    input  wire  [boxds_pkg::LINE_W-1:0]        i_line_rdata,
    input  wire                                 i_out_ready,
    output logic [boxds_pkg::LINE_W-1:0]        o_line_wdata,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    output logic [boxds_pkg::CH_W-1:0]          o_red,
    output logic [boxds_pkg::CH_W-1:0]          o_green,
    output logic [boxds_pkg::CH_W-1:0]          o_blue,
    output logic                                o_done,
    output boxds_pkg::t_avg_status              o_status
);

    localparam int CH_W  = boxds_pkg::CH_W;
    localparam int SUM_W = boxds_pkg::SUM_W;
    localparam int TOT_W = SUM_W + 1;

    boxds_pkg::t_pixel r_held;

    logic                          r_s1_valid;
    logic [boxds_pkg::LINE_W-1:0]  r_s1_sum;
    logic                          r_s1_done;
    logic                          r_out_valid;

    logic [SUM_W-1:0] pair_r;
    logic [SUM_W-1:0] pair_g;
    logic [SUM_W-1:0] pair_b;
    logic [TOT_W-1:0] tot_r;
    logic [TOT_W-1:0] tot_g;
    logic [TOT_W-1:0] tot_b;
    logic             s1_adv;
    logic             emit;

    // horizontal pair sum: held first pixel plus current pixel
    assign pair_r = {1'b0, r_held.red}   + {1'b0, i_pixel.red};
    assign pair_g = {1'b0, r_held.green} + {1'b0, i_pixel.green};
    assign pair_b = {1'b0, r_held.blue}  + {1'b0, i_pixel.blue};
    assign o_line_wdata = {pair_b, pair_g, pair_r};

    // flow control: stage 1 moves when the output register is free or drains
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign emit       = i_accept && i_info.pair_end && i_info.row_odd;

    // first pixel of each pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_accept && !i_info.pair_end) begin
            r_held <= i_pixel;
        end
    end

    // stage 1: pair sum waits for the line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (emit) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_sum  <= o_line_wdata;
            r_s1_done <= i_info.frame_last;
        end
    end

    // vertical add of the stored pair from the row above, then divide by four
    assign tot_r = {1'b0, r_s1_sum[SUM_W-1:0]}         + {1'b0, i_line_rdata[SUM_W-1:0]};
    assign tot_g = {1'b0, r_s1_sum[2*SUM_W-1:SUM_W]}   + {1'b0, i_line_rdata[2*SUM_W-1:SUM_W]};
    assign tot_b = {1'b0, r_s1_sum[3*SUM_W-1:2*SUM_W]} + {1'b0, i_line_rdata[3*SUM_W-1:2*SUM_W]};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            o_red   <= tot_r[TOT_W-1:TOT_W-CH_W];
            o_green <= tot_g[TOT_W-1:TOT_W-CH_W];
            o_blue  <= tot_b[TOT_W-1:TOT_W-CH_W];
            o_done  <= r_s1_done;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.s1_valid  = r_s1_valid;
    assign o_status.out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ bench/box_average_downscale_2x2_core_tb.sv @@
// Self-checking testbench for the 2x2 box-average RGB downscaler.
`timescale 1ns / 1ps

module box_average_downscale_2x2_core_tb;
    import boxds_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int LINE_SLOTS    = MAX_W / 2;
    localparam int SETTLE_CYCLES = 4;     // output passes the line store read, then the output register
    localparam int RANDOM_PIXELS = 1900;
    localparam int CALM_AFTER    = 1600;  // no idling on either side past this
    localparam int WIDE_AFTER    = 500;   // when the saturated-width frame runs
    localparam int BURST_CAP     = 300;
    localparam int OPENING_LEN   = 31;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} t_step_kind;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_done;
    } t_avg_result;

    typedef struct packed {
        t_step_kind   kind;
        logic         reg_sel;
        logic [15:0]  value;    // register value for writes
        t_pixel       pixel;    // {blue, green, red}
        logic         typed;    // result below is fixed, not predicted
        t_avg_result  result;
    } t_step_row;

    // Opening sequence: full-scale and zero blocks, three pure-channel pixels and a grey
    // one, odd trailing column and row, then widths that can never complete a pair.
    localparam t_step_row OPENING_STEPS [OPENING_LEN] = '{
        '{STEP_WRITE, REG_IMAGE_WIDTH,  16'd2, 24'h0, 1'b0, '0},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'd2, 24'h0, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hFFFFFF, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hFFFFFF, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hFFFFFF, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hFFFFFF, 1'b1, {8'd255, 8'd255, 8'd255, 1'b1}},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h000000, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h000000, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h000000, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h000000, 1'b1, {8'd0, 8'd0, 8'd0, 1'b1}},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h0000FF, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h00FF00, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hFF0000, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h030303, 1'b0, '0},
        '{STEP_WRITE, REG_IMAGE_WIDTH,  16'd3, 24'h0, 1'b0, '0},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'd3, 24'h0, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h1E140A, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h3C3228, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h636363, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h030201, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h060504, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h070707, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hC8C8C8, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hC8C8C8, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hC8C8C8, 1'b0, '0},
        '{STEP_WRITE, REG_IMAGE_WIDTH,  16'd1, 24'h0, 1'b0, '0},
        '{STEP_WRITE, REG_IMAGE_HEIGHT, 16'd2, 24'h0, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h123456, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'hABCDEF, 1'b0, '0},
        '{STEP_WRITE, REG_IMAGE_WIDTH,  16'd0, 24'h0, 1'b0, '0},
        '{STEP_PIXEL, 1'b0, 16'd0, 24'h5A5A5A, 1'b0, '0}
    };

    // DUT-facing signals
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [CH_W-1:0]    i_red_in = '0;
    logic [CH_W-1:0]    i_green_in = '0;
    logic [CH_W-1:0]    i_blue_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [CH_W-1:0]    o_red_out;
    logic [CH_W-1:0]    o_green_out;
    logic [CH_W-1:0]    o_blue_out;
    logic               o_frame_done;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state
    logic [WIDTH_REG_W-1:0]  width_cfg = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_cfg = HEIGHT_RESET;
    int                      col_pos = 0;
    int                      row_pos = 0;
    t_pixel                  held_px = '0;
    logic [LINE_W-1:0]       pair_sums [LINE_SLOTS];

    t_avg_result avg_expected [$];

    // bookkeeping
    logic calm = 1'b0;
    int   fail_count = 0;
    int   pixels_sent = 0;
    int   blocks_seen = 0;
    int   frames_closed = 0;
    int   reg_writes = 0;
    int   out_stall = 0;

    box_average_downscale_2x2_core #(
        .MAX_WIDTH    (MAX_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_done (o_frame_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int eff_width();
        return (width_cfg > MAX_W) ? MAX_W : int'(width_cfg);
    endfunction

    // Pixels until both raster counters are back at zero
    function automatic int pixels_left_in_frame();
        int w, h, rest_of_row, rows_after;
        w = eff_width();
        h = int'(height_cfg);
        rest_of_row = (col_pos + 1 >= w) ? 1 : w - col_pos;
        rows_after = (row_pos + 1 >= h) ? 0 : h - row_pos - 1;
        return rest_of_row + rows_after * ((w > 1) ? w : 1);
    endfunction

    // Predictor: one pixel in, at most one averaged block out
    function automatic void average_pixel(input t_pixel px, output logic produced,
                                          output t_avg_result res);
        int w, h, slot, sr, sg, sb;
        logic [LINE_W-1:0] above;
        w = eff_width();
        h = int'(height_cfg);
        slot = col_pos / 2;
        produced = 1'b0;
        res = '0;
        if (col_pos % 2 == 0) begin
            held_px = px;
        end else begin
            sr = int'(held_px.red) + int'(px.red);
            sg = int'(held_px.green) + int'(px.green);
            sb = int'(held_px.blue) + int'(px.blue);
            if (row_pos % 2 == 0) begin
                pair_sums[slot] = {SUM_W'(sb), SUM_W'(sg), SUM_W'(sr)};
            end else begin
                above = pair_sums[slot];
                res.red = CH_W'((sr + int'(above[SUM_W-1:0])) >> 2);
                res.green = CH_W'((sg + int'(above[2*SUM_W-1:SUM_W])) >> 2);
                res.blue = CH_W'((sb + int'(above[3*SUM_W-1:2*SUM_W])) >> 2);
                res.frame_done = (w >= 2) && (h >= 2) && (col_pos == (w & ~1) - 1)
                                 && (row_pos == (h & ~1) - 1);
                produced = 1'b1;
            end
        end
        // raster counters
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CH_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 19))
            0: return 16'($urandom_range(0, 1));
            1: return 16'(MAX_W);
            2, 3: return 16'($urandom_range(17, 80));
            default: return 16'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [15:0] pick_height();
        case ($urandom_range(0, 19))
            0: return 16'($urandom_range(0, 1));
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(9, 40));
            default: return 16'($urandom_range(2, 8));
        endcase
    endfunction

    // One pixel transaction; valid stays up across back-to-back pixels
    task automatic send_pixel(input t_pixel px, input logic use_typed,
                              input t_avg_result typed_res);
        t_avg_result res;
        logic produced;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red_in <= px.red;
        i_green_in <= px.green;
        i_blue_in <= px.blue;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        average_pixel(px, produced, res);
        if (use_typed)
            avg_expected.push_back(typed_res);
        else if (produced)
            avg_expected.push_back(res);
        pixels_sent++;
    endtask

    // Stop sending and wait until the block has nothing left in flight
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (avg_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic sel, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {sel, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic sel, input logic [31:0] want);
        logic [31:0] got;
        apb_access(sel, 1'b0, '0, got);
        if (got !== want) begin
            $error("%s readback: expected %0d, got %0d",
                   (sel == REG_IMAGE_WIDTH) ? "image_width" : "image_height", want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(input logic sel, input logic [15:0] value);
        logic [31:0] unused;
        apb_access(sel, 1'b1, 32'(value), unused);
        if (sel == REG_IMAGE_WIDTH)
            width_cfg = value[WIDTH_REG_W-1:0];
        else
            height_cfg = value;
        reg_writes++;
        check_reg(sel, (sel == REG_IMAGE_WIDTH) ? 32'(value[WIDTH_REG_W-1:0]) : 32'(value));
    endtask

    // Receiver: ready drops in random bursts until the calm tail
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            out_stall <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each output transaction with the oldest expected block
    always @(posedge i_clk) begin
        t_avg_result seen, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_red_out, o_green_out, o_blue_out, o_frame_done};
            blocks_seen++;
            if (o_frame_done)
                frames_closed++;
            if (avg_expected.size() == 0) begin
                $error("output with no block pending: red %0d green %0d blue %0d done %0b",
                       seen.red, seen.green, seen.blue, seen.frame_done);
                fail_count++;
            end else begin
                want = avg_expected.pop_front();
                if (seen.red !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, seen.red);
                    fail_count++;
                end
                if (seen.green !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, seen.green);
                    fail_count++;
                end
                if (seen.blue !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, seen.blue);
                    fail_count++;
                end
                if (seen.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done,
                           seen.frame_done);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        int   burst;
        int   random_pixels;
        logic wide_done;
        logic wide_phase;
        random_pixels = 0;
        wide_done = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_IMAGE_WIDTH, 32'(WIDTH_RESET));
        check_reg(REG_IMAGE_HEIGHT, 32'(HEIGHT_RESET));

        // directed opening
        foreach (OPENING_STEPS[i]) begin
            if (OPENING_STEPS[i].kind == STEP_WRITE) begin
                drain_outputs();
                write_reg(OPENING_STEPS[i].reg_sel, OPENING_STEPS[i].value);
            end else begin
                send_pixel(OPENING_STEPS[i].pixel, OPENING_STEPS[i].typed,
                           OPENING_STEPS[i].result);
            end
        end

        // Random bursts. Sizes change only on an even row, so every line entry an
        // odd row reads was filled by the even row just above it.
        while (random_pixels < RANDOM_PIXELS) begin
            calm = (random_pixels >= CALM_AFTER);
            burst = 0;
            wide_phase = 1'b0;
            if (row_pos % 2 == 0) begin
                if (!wide_done && random_pixels >= WIDE_AFTER) begin
                    // width above the maximum saturates; run one whole frame of it
                    drain_outputs();
                    write_reg(REG_IMAGE_WIDTH, 16'hFFF);
                    write_reg(REG_IMAGE_HEIGHT, 16'd2);
                    burst = pixels_left_in_frame() + 2 * MAX_W;
                    wide_done = 1'b1;
                    wide_phase = 1'b1;
                end else if ($urandom_range(0, 2) == 0) begin
                    drain_outputs();
                    if ($urandom_range(0, 2) != 0)
                        write_reg(REG_IMAGE_WIDTH, pick_width());
                    if ($urandom_range(0, 2) != 0)
                        write_reg(REG_IMAGE_HEIGHT, pick_height());
                end
            end
            if (burst == 0) begin
                if ($urandom_range(0, 4) < 3) begin
                    burst = pixels_left_in_frame();
                    if (burst > BURST_CAP)
                        burst = BURST_CAP;
                end else begin
                    burst = $urandom_range(1, 3 * eff_width() + 2);
                end
            end
            // hold the sender until the pipeline is empty
            if (!calm && $urandom_range(0, 9) == 0)
                drain_outputs();
            repeat (burst) begin
                send_pixel({rand_channel(), rand_channel(), rand_channel()}, 1'b0, '0);
                if (!wide_phase)
                    random_pixels++;
            end
        end

        drain_outputs();
        repeat (8) @(posedge i_clk);
        $display("Run: %0d pixels in, %0d averaged blocks out, %0d frame ends, %0d size writes",
                 pixels_sent, blocks_seen, frames_closed, reg_writes);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
